// ===== rtl/core/pamqe_pkg.sv =====
// Package for the particle age, move and quad expansion block.
// Holds reset values, register indexes and a shared saturation helper.
// Depends on nothing.
package pamqe_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MOVE_SHIFT    = 22;

    localparam logic [31:0] FRAME_TIME_RST = 32'd1092;
    localparam logic [31:0] SIZE_BIRTH_RST = 32'd65536;
    localparam logic [31:0] SIZE_DEATH_RST = 32'd262144;

    typedef enum logic [1:0] {
        REG_FRAME_TIME = 2'd0,
        REG_SIZE_BIRTH = 2'd1,
        REG_SIZE_DEATH = 2'd2
    } reg_idx_t;

    function automatic logic [31:0] sat32(input logic signed [42:0] v);
        logic [31:0] r;
        if (v > 43'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -43'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/particle_age_move_quad_expand_top.sv =====
// Top level of the particle age, move and billboard quad expansion block.
// Depends on pamqe_pkg for reset values, register indexes and saturation.
//
// Usage:
// Particle records enter on the in_* channel by valid/ready; each transfer
// takes one record. Results leave on the out_* channel by valid/ready: a
// living particle gives four corner results in uv order, the fourth with
// last set; a dead particle gives one result with alive low and last set.
// Configuration (frame time, birth and death size) is written through
// cfg_we, cfg_addr and cfg_wdata while the block is idle; index 3 is ignored.
// The pipeline takes one record per cycle while the output stage can accept
// it; the output stage emits one result per cycle while out_ready is high, so
// a living particle holds the pipeline until its fourth result is taken, and
// dead ones pass at one per cycle. The normalized age divider resolves one
// quotient bit per pipeline stage.
// Reset empties the pipeline and loads the default register values.
// When the receiver stalls, the whole pipeline holds and in_ready falls;
// nothing is lost or repeated.
module particle_age_move_quad_expand_top
    import pamqe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] age,
    input  logic [31:0] lifetime,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic [15:0] speed,
    input  logic [31:0] color_birth,
    input  logic [31:0] color_death,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        alive,
    output logic signed [31:0] corner_x,
    output logic signed [31:0] corner_y,
    output logic signed [31:0] corner_z,
    output logic [1:0]  uv_corner,
    output logic [31:0] vertex_color,
    output logic [31:0] new_age,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [31:0] new_z,
    output logic        last
);

    localparam int TW = FRAC_BITS + 1;
    localparam int SL = FRAC_BITS + 2;
    localparam int SE = FRAC_BITS + 3;

    typedef struct packed {
        logic                     dead;
        logic [31:0]              nage;
        logic [31:0]              life;
        logic [2:0][31:0]         pos;
        logic [31:0]              col_b;
        logic [31:0]              col_d;
        logic [2:0]               neg;
        logic [2:0][62:0]         prod;
        logic [31:0]              rem;
        logic [TW-1:0]            quo;
        logic                     sz_ge;
        logic [32+TW-1:0]         sz_m;
        logic [3:0]               c_ge;
        logic [3:0][8+TW-1:0]     c_m;
        logic [31:0]              half;
        logic [31:0]              col;
    } item_t;

    logic [31:0] frame_time_reg;
    logic [31:0] size_birth_reg;
    logic [31:0] size_death_reg;

    item_t       stg_reg [0:SE];
    logic        vld_reg [0:SE];
    item_t       stg_next [0:SE];

    logic        advance;

    logic        o_valid_reg;
    logic [1:0]  cnt_reg;
    logic        o_dead_reg;
    logic [31:0] o_nage_reg;
    logic [2:0][31:0] o_pos_reg;
    logic [31:0] o_col_reg;
    logic [31:0] o_xm_reg;
    logic [31:0] o_xp_reg;
    logic [31:0] o_ym_reg;
    logic [31:0] o_yp_reg;
    logic        o_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_time_reg <= FRAME_TIME_RST;
            size_birth_reg <= SIZE_BIRTH_RST;
            size_death_reg <= SIZE_DEATH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_TIME: frame_time_reg <= cfg_wdata;
                REG_SIZE_BIRTH: size_birth_reg <= cfg_wdata;
                REG_SIZE_DEATH: size_death_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [32:0]        nsum;
        logic [15:0]        mag;
        logic [31:0]        dirs [0:2];
        logic [62:0]        rs;
        logic [40:0]        stp;
        logic signed [42:0] pw;
        logic [32:0]        rsh;
        logic [TW-1:0]      tt;
        logic [31:0]        sd;
        logic [32+TW-1:0]   rsz;
        logic [31:0]        stepl;
        logic [31:0]        sz;
        logic [7:0]         ca;
        logic [7:0]         cb;
        logic [7:0]         cd;
        logic [8+TW-1:0]    rc;
        logic [7:0]         stc;
        logic [7:0]         ch;

        stg_next[0] = '0;
        nsum = {1'b0, age} + {1'b0, frame_time_reg};
        stg_next[0].nage  = nsum[32] ? 32'hFFFF_FFFF : nsum[31:0];
        stg_next[0].life  = lifetime;
        stg_next[0].dead  = (stg_next[0].nage > lifetime);
        stg_next[0].pos   = {pos_z, pos_y, pos_x};
        stg_next[0].col_b = color_birth;
        stg_next[0].col_d = color_death;
        stg_next[0].rem   = {1'b0, stg_next[0].nage[31:1]};
        dirs[0] = 32'(dir_x);
        dirs[1] = 32'(dir_y);
        dirs[2] = 32'(dir_z);
        for (int a = 0; a < 3; a++)
        begin
            stg_next[0].neg[a] = dirs[a][15];
            mag = dirs[a][15] ? 16'(-dirs[a][15:0]) : dirs[a][15:0];
            stg_next[0].prod[a] = 63'({16'd0, mag} * {16'd0, speed});
        end

        for (int s = 1; s <= SE; s++)
        begin
            stg_next[s] = stg_reg[s-1];
            if (s == 1)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    stg_next[s].prod[a] = {31'd0, stg_reg[s-1].prod[a][31:0]}
                                          * {31'd0, frame_time_reg};
                end
            end
            if (s == 2)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rs  = stg_reg[s-1].prod[a] + (63'd1 << (MOVE_SHIFT - 1));
                    stp = rs[62:MOVE_SHIFT];
                    pw  = 43'(signed'(stg_reg[s-1].pos[a]));
                    if (stg_reg[s-1].neg[a])
                    begin
                        pw = pw - signed'({2'b00, stp});
                    end
                    else
                    begin
                        pw = pw + signed'({2'b00, stp});
                    end
                    if (!stg_reg[s-1].dead)
                    begin
                        stg_next[s].pos[a] = sat32(pw);
                    end
                end
            end
            if (s <= TW)
            begin
                rsh = {stg_reg[s-1].rem, (s == 1) ? stg_reg[s-1].nage[0] : 1'b0};
                if (rsh >= {1'b0, stg_reg[s-1].life})
                begin
                    rsh = rsh - {1'b0, stg_reg[s-1].life};
                    stg_next[s].quo = {stg_reg[s-1].quo[TW-2:0], 1'b1};
                end
                else
                begin
                    stg_next[s].quo = {stg_reg[s-1].quo[TW-2:0], 1'b0};
                end
                stg_next[s].rem = rsh[31:0];
            end
            if (s == SL)
            begin
                tt = (stg_reg[s-1].life == 32'd0) ? (TW'(1) << FRAC_BITS)
                                                 : stg_reg[s-1].quo;
                stg_next[s].sz_ge = (size_death_reg >= size_birth_reg);
                sd = stg_next[s].sz_ge ? size_death_reg - size_birth_reg
                                       : size_birth_reg - size_death_reg;
                stg_next[s].sz_m = {{TW{1'b0}}, sd} * {32'd0, tt};
                for (int c = 0; c < 4; c++)
                begin
                    cb = stg_reg[s-1].col_b[8*c +: 8];
                    cd = stg_reg[s-1].col_d[8*c +: 8];
                    stg_next[s].c_ge[c] = (cd >= cb);
                    ca = (cd >= cb) ? cd - cb : cb - cd;
                    stg_next[s].c_m[c] = {{TW{1'b0}}, ca} * {8'd0, tt};
                end
            end
            if (s == SE)
            begin
                rsz   = stg_reg[s-1].sz_m + ((32+TW)'(1) << (FRAC_BITS - 1));
                stepl = 32'(rsz >> FRAC_BITS);
                sz    = stg_reg[s-1].sz_ge ? size_birth_reg + stepl
                                           : size_birth_reg - stepl;
                stg_next[s].half = {1'b0, sz[31:1]};
                for (int c = 0; c < 4; c++)
                begin
                    cb  = stg_reg[s-1].col_b[8*c +: 8];
                    rc  = stg_reg[s-1].c_m[c] + ((8+TW)'(1) << (FRAC_BITS - 1));
                    stc = 8'(rc >> FRAC_BITS);
                    ch  = stg_reg[s-1].c_ge[c] ? cb + stc : cb - stc;
                    stg_next[s].col[8*c +: 8] = ch;
                end
            end
        end
    end

    assign o_last  = o_dead_reg || (cnt_reg == 2'd3);
    assign advance = !o_valid_reg || (out_ready && o_last);
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= SE; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= SE; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s <= SE; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else if (advance)
        begin
            o_valid_reg <= vld_reg[SE];
            cnt_reg     <= 2'd0;
        end
        else if (out_ready)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_dead_reg <= stg_reg[SE].dead;
            o_nage_reg <= stg_reg[SE].nage;
            o_pos_reg  <= stg_reg[SE].pos;
            o_col_reg  <= stg_reg[SE].col;
            o_xm_reg   <= sat32(43'(signed'(stg_reg[SE].pos[0]))
                                - signed'({11'd0, stg_reg[SE].half}));
            o_xp_reg   <= sat32(43'(signed'(stg_reg[SE].pos[0]))
                                + signed'({11'd0, stg_reg[SE].half}));
            o_ym_reg   <= sat32(43'(signed'(stg_reg[SE].pos[1]))
                                - signed'({11'd0, stg_reg[SE].half}));
            o_yp_reg   <= sat32(43'(signed'(stg_reg[SE].pos[1]))
                                + signed'({11'd0, stg_reg[SE].half}));
        end
    end

    assign out_valid    = o_valid_reg;
    assign alive        = !o_dead_reg;
    assign last         = o_last;
    assign corner_x     = o_dead_reg ? 32'sd0 :
                          ((cnt_reg == 2'd1 || cnt_reg == 2'd2) ? o_xp_reg : o_xm_reg);
    assign corner_y     = o_dead_reg ? 32'sd0 : (cnt_reg[1] ? o_yp_reg : o_ym_reg);
    assign corner_z     = o_dead_reg ? 32'sd0 : o_pos_reg[2];
    assign uv_corner    = o_dead_reg ? 2'd0 : cnt_reg;
    assign vertex_color = o_dead_reg ? 32'd0 : o_col_reg;
    assign new_age      = o_nage_reg;
    assign new_x        = o_pos_reg[0];
    assign new_y        = o_pos_reg[1];
    assign new_z        = o_pos_reg[2];

`ifndef SYNTHESIS
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !o_valid_reg |-> cnt_reg == 2'd0)
        else $error("corner count moved without a pending result");
    a_dead_last: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_dead_reg) |-> o_last)
        else $error("dead particle result not marked last");
    a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && uv_corner == 2'($past(uv_corner) + 2'd1)))
        else $error("corner sequence broken");
    a_hold_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("pipeline advanced under output stall");
`endif

endmodule
